// File: src/scrl_pkg.sv
// scrl_pkg: types and constants of the scroll and address register unit
// no dependencies; imported by every other file of the project
`timescale 1ns / 1ps
`default_nettype none

package scrl_pkg;

	// event codes
	localparam logic [3:0] OP_CTRL_WR   = 4'd0;
	localparam logic [3:0] OP_SCROLL_WR = 4'd1;
	localparam logic [3:0] OP_ADDR_WR   = 4'd2;
	localparam logic [3:0] OP_STATUS_RD = 4'd3;
	localparam logic [3:0] OP_DATA_ACC  = 4'd4;
	localparam logic [3:0] OP_INC_HORIZ = 4'd5;
	localparam logic [3:0] OP_INC_VERT  = 4'd6;
	localparam logic [3:0] OP_COPY_HORIZ = 4'd7;
	localparam logic [3:0] OP_COPY_VERT = 4'd8;

	localparam int unsigned ADDR_W = 15;

	// coarse Y wrap points
	localparam logic [4:0] COARSE_Y_LAST_ROW = 5'd29;
	localparam logic [4:0] COARSE_MAX        = 5'd31;
	localparam logic [2:0] FINE_Y_MAX        = 3'd7;

	// bits moved by the horizontal and vertical copies
	localparam logic [ADDR_W-1:0] HORIZ_BITS = 15'h041F;
	localparam logic [ADDR_W-1:0] VERT_BITS  = 15'h7BE0;

	typedef struct packed {
		logic [3:0] opcode;
		logic [7:0] data;
		logic       rendering_enabled;
	} scrl_evt_t;

	typedef struct packed {
		logic [13:0] bus_address;
		logic [14:0] current_address;
		logic [2:0]  fine_scroll_x;
		logic        write_toggle;
	} scrl_res_t;

	typedef struct packed {
		logic [ADDR_W-1:0] v;
		logic [ADDR_W-1:0] t;
		logic [2:0]        fine_x;
		logic              toggle;
		logic              inc32;
	} scrl_state_t;

endpackage

`default_nettype wire

// File: src/scrl_next.sv
// scrl_next: next register state and result item for one event
// depends on scrl_pkg
`timescale 1ns / 1ps
`default_nettype none

module scrl_next (
	input  var scrl_pkg::scrl_state_t cur,
	input  var scrl_pkg::scrl_evt_t   evt,
	output scrl_pkg::scrl_state_t     nxt,
	output scrl_pkg::scrl_res_t       res
);
	import scrl_pkg::*;

	logic [ADDR_W-1:0] v_hinc;
	logic [ADDR_W-1:0] v_vinc;
	logic [4:0]        cy;
	logic [13:0]       bus;

	// coarse X step, nametable X flips past the last column
	always_comb begin
		v_hinc = cur.v;
		if (cur.v[4:0] == COARSE_MAX) begin
			v_hinc[4:0] = '0;
			v_hinc[10]  = ~cur.v[10];
		end else begin
			v_hinc[4:0] = cur.v[4:0] + 5'd1;
		end
	end

	// fine Y step, carry into coarse Y with the row 29 and 31 wraps
	always_comb begin
		v_vinc = cur.v;
		cy     = cur.v[9:5];
		if (cur.v[14:12] != FINE_Y_MAX) begin
			v_vinc[14:12] = cur.v[14:12] + 3'd1;
		end else begin
			v_vinc[14:12] = '0;
			if (cy == COARSE_Y_LAST_ROW) begin
				v_vinc[9:5] = '0;
				v_vinc[11]  = ~cur.v[11];
			end else if (cy == COARSE_MAX) begin
				v_vinc[9:5] = '0;
			end else begin
				v_vinc[9:5] = cy + 5'd1;
			end
		end
	end

	always_comb begin
		nxt = cur;
		bus = '0;
		unique case (evt.opcode)
			OP_CTRL_WR: begin
				nxt.t[11:10] = evt.data[1:0];
				nxt.inc32    = evt.data[2];
			end
			OP_SCROLL_WR: begin
				if (!cur.toggle) begin
					nxt.t[4:0]  = evt.data[7:3];
					nxt.fine_x  = evt.data[2:0];
				end else begin
					nxt.t[9:5]   = evt.data[7:3];
					nxt.t[14:12] = evt.data[2:0];
				end
				nxt.toggle = ~cur.toggle;
			end
			OP_ADDR_WR: begin
				if (!cur.toggle) begin
					nxt.t[13:8] = evt.data[5:0];
					nxt.t[14]   = 1'b0;
				end else begin
					nxt.t[7:0] = evt.data;
					nxt.v      = {cur.t[14:8], evt.data};
				end
				nxt.toggle = ~cur.toggle;
			end
			OP_STATUS_RD: begin
				nxt.toggle = 1'b0;
			end
			OP_DATA_ACC: begin
				bus   = cur.v[13:0];
				nxt.v = cur.v + (cur.inc32 ? 15'd32 : 15'd1);
			end
			OP_INC_HORIZ: begin
				if (evt.rendering_enabled) nxt.v = v_hinc;
			end
			OP_INC_VERT: begin
				if (evt.rendering_enabled) nxt.v = v_vinc;
			end
			OP_COPY_HORIZ: begin
				if (evt.rendering_enabled)
					nxt.v = (cur.v & ~HORIZ_BITS) | (cur.t & HORIZ_BITS);
			end
			OP_COPY_VERT: begin
				if (evt.rendering_enabled)
					nxt.v = (cur.v & ~VERT_BITS) | (cur.t & VERT_BITS);
			end
			default: begin
			end
		endcase
	end

	assign res.bus_address     = bus;
	assign res.current_address = nxt.v;
	assign res.fine_scroll_x   = nxt.fine_x;
	assign res.write_toggle    = nxt.toggle;

endmodule

`default_nettype wire

// File: src/scroll_address_register_unit.sv
// scroll_address_register_unit: video scroll and address registers (v, t, fine x, toggle)
// depends on scrl_pkg and scrl_next
`timescale 1ns / 1ps
`default_nettype none

// channel   | signals                    | item type  | direction
// ----------+----------------------------+------------+----------
// events    | evt_valid, evt_stall, evt  | scrl_evt_t | in
// results   | res_valid, res_stall, res  | scrl_res_t | out
//
// one event per cycle unless evt_stall is high, one result per event
// stage 1 holds the accepted event, the result register holds its result
// the register state updates at the same edge the result is loaded
// a stalled result holds stage 1, stage 1 accepts while it is empty or the result register is free
// reset clears v, t, fine x, toggle, increment mode and both valid flags

module scroll_address_register_unit (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 evt_valid,
	output logic                evt_stall,
	input  var scrl_pkg::scrl_evt_t evt,
	output logic                res_valid,
	input  wire                 res_stall,
	output scrl_pkg::scrl_res_t res
);
	import scrl_pkg::*;

	scrl_evt_t   evt_s1;
	logic        vld_s1;
	scrl_res_t   res_s2;
	logic        vld_s2;
	scrl_state_t state_q;
	scrl_state_t state_nxt;
	scrl_res_t   res_nxt;
	logic        s2_free;
	logic        s1_move;
	logic        evt_take;

	// result register can load when empty or being drained
	assign s2_free   = !vld_s2 || !res_stall;
	assign s1_move   = vld_s1 && s2_free;
	assign evt_stall = vld_s1 && !s2_free;
	assign evt_take  = evt_valid && !evt_stall;

	scrl_next u_next (
		.cur (state_q),
		.evt (evt_s1),
		.nxt (state_nxt),
		.res (res_nxt)
	);

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s2_free || !vld_s1) begin
			vld_s1 <= evt_valid;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (evt_take) begin
			evt_s1 <= evt;
		end
	end

	// architectural registers step with each processed event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (s1_move) begin
			state_q <= state_nxt;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (s2_free) begin
			vld_s2 <= vld_s1;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (s1_move) begin
			res_s2 <= res_nxt;
		end
	end

	assign res_valid = vld_s2;
	assign res       = res_s2;

endmodule

`default_nettype wire

// File: dv/scrl_result_checker.sv
// scrl_result_checker: watches the event and result channels of the scroll unit,
// predicts every result from its own copy of v, t, fine x, toggle and increment mode
// depends on scrl_pkg; instantiated by scroll_address_register_unit_tb
`timescale 1ns / 1ps

module scrl_result_checker (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 evt_valid,
	input  wire                 evt_stall,
	input  var scrl_pkg::scrl_evt_t evt,
	input  wire                 res_valid,
	input  wire                 res_stall,
	input  var scrl_pkg::scrl_res_t res,
	output int unsigned         mismatch_count,
	output int unsigned         outstanding,
	output int unsigned         results_checked
);
	import scrl_pkg::*;

	scrl_state_t scroll_regs;
	scrl_res_t   expected_results[$];
	scrl_res_t   want;

	task automatic report_mismatch(input string what);
		if (mismatch_count < 100)
			$display("[%0t] mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	// applies one event to scroll_regs and returns the result it causes
	function automatic scrl_res_t apply_scroll_event(input scrl_evt_t e);
		scrl_res_t         r;
		logic [ADDR_W-1:0] v;
		logic [ADDR_W-1:0] t;
		logic [4:0]        cy;
		r = '0;
		v = scroll_regs.v;
		t = scroll_regs.t;
		case (e.opcode)
			OP_CTRL_WR: begin
				t[11:10] = e.data[1:0];
				scroll_regs.inc32 = e.data[2];
			end
			OP_SCROLL_WR: begin
				if (!scroll_regs.toggle) begin
					t[4:0] = e.data[7:3];
					scroll_regs.fine_x = e.data[2:0];
					scroll_regs.toggle = 1'b1;
				end else begin
					t[9:5] = e.data[7:3];
					t[14:12] = e.data[2:0];
					scroll_regs.toggle = 1'b0;
				end
			end
			OP_ADDR_WR: begin
				if (!scroll_regs.toggle) begin
					t[13:8] = e.data[5:0];
					t[14] = 1'b0;
					scroll_regs.toggle = 1'b1;
				end else begin
					t[7:0] = e.data;
					v = t;
					scroll_regs.toggle = 1'b0;
				end
			end
			OP_STATUS_RD: scroll_regs.toggle = 1'b0;
			OP_DATA_ACC: begin
				r.bus_address = v[13:0];
				v = v + (scroll_regs.inc32 ? 15'd32 : 15'd1);
			end
			OP_INC_HORIZ: begin
				if (e.rendering_enabled) begin
					if (v[4:0] == COARSE_MAX) begin
						v[4:0] = '0;
						v[10] = ~v[10];
					end else begin
						v[4:0] = v[4:0] + 5'd1;
					end
				end
			end
			OP_INC_VERT: begin
				if (e.rendering_enabled) begin
					if (v[14:12] != FINE_Y_MAX) begin
						v[14:12] = v[14:12] + 3'd1;
					end else begin
						v[14:12] = '0;
						cy = v[9:5];
						if (cy == COARSE_Y_LAST_ROW) begin
							cy = '0;
							v[11] = ~v[11];
						end else if (cy == COARSE_MAX) begin
							cy = '0;
						end else begin
							cy = cy + 5'd1;
						end
						v[9:5] = cy;
					end
				end
			end
			OP_COPY_HORIZ: begin
				if (e.rendering_enabled)
					v = (v & ~HORIZ_BITS) | (t & HORIZ_BITS);
			end
			OP_COPY_VERT: begin
				if (e.rendering_enabled)
					v = (v & ~VERT_BITS) | (t & VERT_BITS);
			end
			default: ;
		endcase
		scroll_regs.v = v;
		scroll_regs.t = t;
		r.current_address = v;
		r.fine_scroll_x = scroll_regs.fine_x;
		r.write_toggle = scroll_regs.toggle;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scroll_regs = '0;
			expected_results.delete();
			outstanding = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("result %h with nothing expected", res));
				end else begin
					want = expected_results.pop_front();
					if (res.bus_address !== want.bus_address)
						report_mismatch($sformatf("bus_address got %h want %h",
							res.bus_address, want.bus_address));
					if (res.current_address !== want.current_address)
						report_mismatch($sformatf("current_address got %h want %h",
							res.current_address, want.current_address));
					if (res.fine_scroll_x !== want.fine_scroll_x)
						report_mismatch($sformatf("fine_scroll_x got %h want %h",
							res.fine_scroll_x, want.fine_scroll_x));
					if (res.write_toggle !== want.write_toggle)
						report_mismatch($sformatf("write_toggle got %b want %b",
							res.write_toggle, want.write_toggle));
					results_checked++;
				end
			end
			if (evt_valid && !evt_stall)
				expected_results.push_back(apply_scroll_event(evt));
			outstanding = expected_results.size();
		end
	end

endmodule

// File: dv/scroll_address_register_unit_tb.sv
// scroll_address_register_unit_tb: stimulus and verdict for the scroll unit
// depends on scrl_pkg, scroll_address_register_unit and scrl_result_checker
`timescale 1ns / 1ps

module scroll_address_register_unit_tb;
	import scrl_pkg::*;

	// codes the block does not define, they must leave everything alone
	localparam logic [3:0] OP_UNUSED_FIRST = 4'd9;
	localparam logic [3:0] OP_UNUSED_LAST  = 4'd15;

	// random events driven in each idling mix
	localparam int unsigned EVENTS_PER_MIX = 262;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        evt_valid = 1'b0;
	logic        evt_stall;
	scrl_evt_t   evt = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	scrl_res_t   res;

	int unsigned mismatch_count;
	int unsigned outstanding;
	int unsigned results_checked;
	int unsigned events_sent = 0;

	// chance in percent of a sender gap and of a receiver stall per cycle
	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;

	scroll_address_register_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.evt       (evt),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	scrl_result_checker u_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.evt_valid       (evt_valid),
		.evt_stall       (evt_stall),
		.evt             (evt),
		.res_valid       (res_valid),
		.res_stall       (res_stall),
		.res             (res),
		.mismatch_count  (mismatch_count),
		.outstanding     (outstanding),
		.results_checked (results_checked)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// receiver back-pressure, redrawn every cycle
	always @(posedge clk) begin
		res_stall <= ($urandom_range(99) < stall_pct);
	end

	// hard stop, far beyond the slowest correct run
	initial begin
		#2_400_000;
		$display("simulation failed");
		$finish;
	end

	// offers one item after a random gap and returns at the edge that takes it
	task automatic send_event(input logic [3:0] op, input logic [7:0] value,
			input logic ren);
		scrl_evt_t item;
		item.opcode = op;
		item.data = value;
		item.rendering_enabled = ren;
		while ($urandom_range(99) < idle_pct) begin
			evt_valid <= 1'b0;
			@(posedge clk);
		end
		evt_valid <= 1'b1;
		evt <= item;
		do @(posedge clk); while (evt_stall);
		events_sent++;
	endtask

	// sender holds off until every predicted result has been seen
	task automatic wait_for_results();
		evt_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// rendering is mostly on so the render events actually move v
	function automatic logic render_on();
		return ($urandom_range(9) != 0);
	endfunction

	// random byte for the data field
	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(255));
	endfunction

	// random level for rendering enabled
	function automatic logic rand_bit();
		return 1'($urandom_range(1));
	endfunction

	// one random sequence: render runs, scroll setup, address setup or noise
	task automatic random_sequence();
		int unsigned pick;
		int unsigned n;
		pick = $urandom_range(99);
		if (pick < 35) begin
			// part of a scanline: coarse x steps, then the end-of-line events
			n = $urandom_range(1, 12);
			repeat (n) send_event(OP_INC_HORIZ, rand_byte(), render_on());
			if ($urandom_range(1))
				send_event(OP_INC_VERT, rand_byte(), render_on());
			if ($urandom_range(1))
				send_event(OP_COPY_HORIZ, rand_byte(), render_on());
		end else if (pick < 60) begin
			// frame setup through the scroll register, then copy into v
			send_event(OP_STATUS_RD, rand_byte(), rand_bit());
			send_event(OP_CTRL_WR, rand_byte(), rand_bit());
			send_event(OP_SCROLL_WR, rand_byte(), rand_bit());
			send_event(OP_SCROLL_WR, rand_byte(), rand_bit());
			send_event(OP_COPY_VERT, rand_byte(), render_on());
			send_event(OP_COPY_HORIZ, rand_byte(), render_on());
			n = $urandom_range(0, 8);
			repeat (n) send_event(OP_INC_VERT, rand_byte(), render_on());
		end else if (pick < 80) begin
			// processor memory access through the address register
			if ($urandom_range(3) != 0)
				send_event(OP_STATUS_RD, rand_byte(), rand_bit());
			if ($urandom_range(2) == 0)
				send_event(OP_CTRL_WR, rand_byte(), rand_bit());
			send_event(OP_ADDR_WR, rand_byte(), rand_bit());
			send_event(OP_ADDR_WR, rand_byte(), rand_bit());
			n = $urandom_range(1, 4);
			repeat (n) send_event(OP_DATA_ACC, rand_byte(), rand_bit());
		end else begin
			// any code at all, undefined ones included
			send_event(4'($urandom_range(15)), rand_byte(), rand_bit());
		end
	endtask

	initial begin
		int unsigned goal;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: increment by 32, then the wrap cases of both increments
		send_event(OP_CTRL_WR, 8'hFF, 1'b1);
		send_event(OP_DATA_ACC, 8'h00, 1'b0);
		send_event(OP_SCROLL_WR, 8'hFF, 1'b1);
		send_event(OP_SCROLL_WR, 8'hEF, 1'b1);
		send_event(OP_COPY_HORIZ, 8'h00, 1'b1);
		send_event(OP_COPY_VERT, 8'h00, 1'b1);
		// rendering off, v must stay put
		send_event(OP_INC_VERT, 8'hFF, 1'b0);
		// coarse x at 31, then fine y 7 with coarse y at 29
		send_event(OP_INC_HORIZ, 8'h00, 1'b1);
		send_event(OP_INC_VERT, 8'h00, 1'b1);
		// status read drops a half-done write
		send_event(OP_SCROLL_WR, 8'h00, 1'b0);
		send_event(OP_STATUS_RD, 8'hFF, 1'b1);
		// coarse y at 31 wraps without flipping the nametable
		send_event(OP_SCROLL_WR, 8'h07, 1'b0);
		send_event(OP_SCROLL_WR, 8'hFF, 1'b0);
		send_event(OP_COPY_VERT, 8'hFF, 1'b1);
		send_event(OP_INC_VERT, 8'hFF, 1'b1);
		// address write with all ones, bit 14 forced low
		send_event(OP_ADDR_WR, 8'hFF, 1'b0);
		send_event(OP_ADDR_WR, 8'hFF, 1'b0);
		// build v = 7fff through t and wrap it with a data access
		send_event(OP_CTRL_WR, 8'h03, 1'b0);
		send_event(OP_SCROLL_WR, 8'hFF, 1'b1);
		send_event(OP_SCROLL_WR, 8'hFF, 1'b1);
		send_event(OP_COPY_HORIZ, 8'hFF, 1'b1);
		send_event(OP_COPY_VERT, 8'hFF, 1'b1);
		send_event(OP_DATA_ACC, 8'hFF, 1'b1);
		send_event(OP_UNUSED_FIRST, 8'hFF, 1'b1);
		send_event(OP_UNUSED_LAST, 8'hFF, 1'b1);
		wait_for_results();

		// random: four idling mixes, drained between them
		for (int mix = 0; mix < 4; mix++) begin
			case (mix)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 58;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 58;
				end
				default: begin
					idle_pct = 31;
					stall_pct = 31;
				end
			endcase
			goal = events_sent + EVENTS_PER_MIX;
			while (events_sent < goal) random_sequence();
			wait_for_results();
		end

		// idle on with no stalls so a stray extra result would still be caught
		stall_pct = 0;
		repeat (6) @(posedge clk);

		$display("%0d events driven under four idling mixes, %0d results compared",
			events_sent, results_checked);
		if (mismatch_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
